// File: hw/rtl/pltd_pkg.sv
package pltd_pkg;

	// opcodes carried in the input tuser
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// entry code boundaries of the delta table
	localparam logic [7:0] CODE_LONG     = 8'd0;
	localparam logic [7:0] CODE_ADD_MAX  = 8'd64;
	localparam logic [7:0] CODE_SUB_MAX  = 8'd128;

	// bytes that follow a long-delta code
	localparam logic [2:0] LONG_BYTES = 3'd4;

	// one input item as it sits in the input register
	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  table_byte;
		logic [63:0] start_pc;
		logic [31:0] start_line;
		logic [63:0] target_pc;
	} item_t;

	// one result item out of the decoder core
	typedef struct packed {
		logic        valid;
		logic [31:0] line_number;
		logic        reached_target;
	} result_t;

endpackage

// File: hw/rtl/pltd_core.sv
module pltd_core import pltd_pkg::*; #(
	parameter int PC_QUANTUM = 1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	// widest pc advance of one entry is 127 quanta, the entry's own quantum included
	localparam int QW = $clog2(128 * PC_QUANTUM + 1);

	logic [63:0] cur_pc_q;
	logic [31:0] cur_line_q;
	logic [63:0] goal_pc_q;
	logic        answered_q;
	logic [2:0]  pending_q;
	logic [31:0] delta_q;

	logic [63:0] pc_d;
	logic [31:0] line_d;
	logic [63:0] goal_d;
	logic        answered_d;
	logic [2:0]  pending_d;
	logic [31:0] delta_d;
	logic [6:0]  pc_steps;
	logic [QW-1:0] pc_inc;
	logic [31:0] acc_next;
	logic        reached;

	// pc advance of a finished entry, in bytes
	assign pc_steps = (item.table_byte > CODE_SUB_MAX) ?
		7'(item.table_byte - CODE_SUB_MAX) : 7'd1;
	assign pc_inc   = QW'(pc_steps) * QW'(PC_QUANTUM);
	assign acc_next = {delta_q[23:0], item.table_byte};
	assign reached  = (cur_pc_q >= goal_pc_q);

	// next state and result for the item in the input register
	always_comb begin
		pc_d       = cur_pc_q;
		line_d     = cur_line_q;
		goal_d     = goal_pc_q;
		answered_d = answered_q;
		pending_d  = pending_q;
		delta_d    = delta_q;
		res        = '{valid: 1'b0, line_number: cur_line_q, reached_target: 1'b0};
		unique case (item.opcode)
			OP_START: begin
				pc_d       = item.start_pc;
				line_d     = item.start_line;
				goal_d     = item.target_pc;
				answered_d = 1'b0;
				pending_d  = '0;
				delta_d    = '0;
			end
			OP_END: begin
				if (!answered_q) begin
					res.valid  = 1'b1;
					answered_d = 1'b1;
					pending_d  = '0;
					delta_d    = '0;
				end
			end
			OP_BYTE: begin
				if (!answered_q) begin
					if (pending_q != '0) begin
						// tail byte of a long delta
						pending_d = pending_q - 3'd1;
						delta_d   = acc_next;
						if (pending_q == 3'd1) begin
							line_d  = cur_line_q + acc_next;
							pc_d    = cur_pc_q + 64'(PC_QUANTUM);
							delta_d = '0;
						end
					end else if (reached) begin
						res.valid          = 1'b1;
						res.reached_target = 1'b1;
						answered_d         = 1'b1;
						pending_d          = '0;
						delta_d            = '0;
					end else if (item.table_byte == CODE_LONG) begin
						pending_d = LONG_BYTES;
						delta_d   = '0;
					end else begin
						if (item.table_byte <= CODE_ADD_MAX) begin
							line_d = cur_line_q + 32'(item.table_byte);
						end else if (item.table_byte <= CODE_SUB_MAX) begin
							line_d = cur_line_q + 32'(CODE_ADD_MAX) - 32'(item.table_byte);
						end
						pc_d = cur_pc_q + 64'(pc_inc);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pc_q   <= '0;
			cur_line_q <= '0;
			goal_pc_q  <= '0;
			answered_q <= 1'b1;
			pending_q  <= '0;
			delta_q    <= '0;
		end else if (en) begin
			cur_pc_q   <= pc_d;
			cur_line_q <= line_d;
			goal_pc_q  <= goal_d;
			answered_q <= answered_d;
			pending_q  <= pending_d;
			delta_q    <= delta_d;
		end
	end

	// a start opens a fresh query
	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.opcode == OP_START |=> !answered_q && pending_q == '0)
		else $error("start did not open a query");

	// a result closes the query and drops any partial delta
	a_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.valid |=> answered_q && pending_q == '0 && delta_q == '0)
		else $error("result left the query open");

	// a long delta is only gathered inside an open query
	a_pending_open: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != '0 |-> !answered_q && pending_q <= LONG_BYTES)
		else $error("long delta outside an open query");

endmodule

// File: hw/rtl/pc_line_table_decoder_unit.sv
// Decodes a pc to line delta table one byte per cycle. An item with opcode
// start loads the start pc, start line and target pc; table byte items walk
// the table; an end item closes the query. At most one result comes out per
// query: the line, with reached_target set when the running pc got to the
// target before the table ended. Items pass an input register and the
// decode logic (a 64-bit pc add and compare) into an output register, so
// a new item is taken every cycle while the result side keeps up.
module pc_line_table_decoder_unit import pltd_pkg::*; #(
	parameter int PC_QUANTUM = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// table_byte[7:0], start_pc[71:8], start_line[103:72], target_pc[167:104]
	input  logic [167:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// line_number[31:0]
	output logic [31:0]  m_axis_tdata,
	// reached_target[0]
	output logic         m_axis_tuser
);

	logic        valid_s1;
	item_t       item_s1;
	logic        adv;
	result_t     res;
	logic        out_valid_q;
	logic [31:0] out_line_q;
	logic        out_hit_q;

	// the input register moves on whenever the output register is free
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.opcode     <= s_axis_tuser;
			item_s1.table_byte <= s_axis_tdata[7:0];
			item_s1.start_pc   <= s_axis_tdata[71:8];
			item_s1.start_line <= s_axis_tdata[103:72];
			item_s1.target_pc  <= s_axis_tdata[167:104];
		end
	end

	pltd_core #(
		.PC_QUANTUM(PC_QUANTUM)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (valid_s1 && adv),
		.item  (item_s1),
		.res   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res.valid) begin
			out_line_q <= res.line_number;
			out_hit_q  <= res.reached_target;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_line_q;
	assign m_axis_tuser  = out_hit_q;

	// only byte and end items can give a result
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && res.valid |->
			item_s1.opcode == OP_BYTE || item_s1.opcode == OP_END)
		else $error("result from a start or unknown item");

	// a waiting result is not overwritten
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_line_q))
		else $error("waiting result lost");

	// the result of an end item never reports the target reached
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && item_s1.opcode == OP_END && res.valid |->
			!res.reached_target)
		else $error("end item reported target reached");

endmodule

// File: tb/tb_top.sv
module tb_top;
	import pltd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          QUANTUM      = 1;
	localparam logic [1:0]  OP_ILLEGAL   = 2'd3;
	localparam logic [7:0]  PC_STEP_BASE = 8'd129;
	localparam int          ITEM_TOTAL   = 1350;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          STALL_LIMIT  = 3000;
	localparam int          DRAIN_CYCLES = 20;

	// tdata layout of one input item, lowest field last
	typedef struct packed {
		logic [63:0] target_pc;
		logic [31:0] start_line;
		logic [63:0] start_pc;
		logic [7:0]  table_byte;
	} table_fields_t;

	typedef struct packed {
		logic [31:0] line;
		logic        hit;
	} line_answer_t;

	// running decode of the table and the line answers it owes
	class line_scoreboard;
		logic [63:0]  pc;
		logic [63:0]  goal;
		logic [31:0]  line;
		bit           done;
		logic [2:0]   owed;
		logic [31:0]  accum;
		line_answer_t answers[$];
		int unsigned  errors;

		function new();
			pc = '0;
			goal = '0;
			line = '0;
			done = 1'b1;
			owed = '0;
			accum = '0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void answer(logic hit);
			answers.push_back('{line: line, hit: hit});
			done = 1'b1;
			owed = '0;
			accum = '0;
		endfunction

		function void note_input(logic [1:0] op, table_fields_t f);
			logic [7:0] b;
			b = f.table_byte;
			case (op)
				OP_START: begin
					pc = f.start_pc;
					line = f.start_line;
					goal = f.target_pc;
					done = 1'b0;
					owed = '0;
					accum = '0;
				end
				OP_END: begin
					if (!done)
						answer(1'b0);
				end
				OP_BYTE: begin
					if (done) begin
						// idle, byte ignored
					end else if (owed != '0) begin
						// tail byte of a long delta, no target check here
						accum = {accum[23:0], b};
						owed = owed - 3'd1;
						if (owed == '0) begin
							line = line + accum;
							pc = pc + 64'(QUANTUM);
							accum = '0;
						end
					end else if (pc >= goal) begin
						answer(1'b1);
					end else if (b == CODE_LONG) begin
						owed = LONG_BYTES;
						accum = '0;
					end else begin
						if (b <= CODE_ADD_MAX)
							line = line + {24'd0, b};
						else if (b <= CODE_SUB_MAX)
							line = line - ({24'd0, b} - {24'd0, CODE_ADD_MAX});
						else
							pc = pc + 64'(QUANTUM) * 64'(b - PC_STEP_BASE);
						pc = pc + 64'(QUANTUM);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [31:0] got_line, logic got_hit);
			line_answer_t want;
			if (answers.size() == 0) begin
				flag($sformatf("unexpected item line %0d reached %0b",
					$signed(got_line), got_hit));
			end else begin
				want = answers.pop_front();
				if (got_line !== want.line)
					flag($sformatf("line expected %0d actual %0d",
						$signed(want.line), $signed(got_line)));
				if (got_hit !== want.hit)
					flag($sformatf("reached expected %0b actual %0b", want.hit, got_hit));
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tuser;

	line_scoreboard sb = new();

	int send_idle_pct = 24;
	int recv_idle_pct = 52;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int stall_cycles = 0;

	pc_line_table_decoder_unit #(
		.PC_QUANTUM(QUANTUM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// accepted items on both sides, plus the stall counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, table_fields_t'(s_axis_tdata));
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// watchdog
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic table_fields_t noise_fields();
		table_fields_t f;
		f.target_pc = rand64();
		f.start_line = $urandom;
		f.start_pc = rand64();
		f.table_byte = 8'($urandom);
		return f;
	endfunction

	// random table entry code, weighted toward small pc steps
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return CODE_LONG;
		else if (r < 38)
			return 8'($urandom_range(1, 64));
		else if (r < 68)
			return 8'($urandom_range(65, 128));
		else if (r < 90)
			return 8'($urandom_range(129, 135));
		else
			return 8'($urandom_range(136, 255));
	endfunction

	task automatic send_item(input logic [1:0] op, input table_fields_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_start(input logic [63:0] spc, input logic [31:0] sline,
			input logic [63:0] tpc);
		table_fields_t f;
		f = noise_fields();
		f.start_pc = spc;
		f.start_line = sline;
		f.target_pc = tpc;
		send_item(OP_START, f);
	endtask

	task automatic send_byte(input logic [7:0] b);
		table_fields_t f;
		f = noise_fields();
		f.table_byte = b;
		send_item(OP_BYTE, f);
	endtask

	// stimulus
	initial begin
		logic [63:0] spc;
		logic [63:0] tpc;
		logic [7:0]  class_codes [6];
		int n;
		int r;
		bit pressure_done;
		pressure_done = 1'b0;
		class_codes = '{8'd65, 8'd128, 8'd1, 8'd64, 8'd129, 8'd255};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes, end and an illegal opcode while idle
		send_byte(8'hA5);
		send_item(OP_END, noise_fields());
		send_item(OP_ILLEGAL, noise_fields());

		// every code class from the most negative line, full and partial long delta
		send_start(64'd0, 32'h8000_0000, 64'd1000);
		foreach (class_codes[i])
			send_byte(class_codes[i]);
		send_byte(CODE_LONG);
		repeat (4) send_byte(8'hFF);
		send_byte(CODE_LONG);
		send_byte(8'h12);
		send_item(OP_ILLEGAL, noise_fields());
		send_item(OP_END, noise_fields());

		// line wraps upward, target hit at the top pc
		send_start(64'hFFFF_FFFF_FFFF_FFFE, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'd1);
		send_byte(8'd1);

		// pc reaches the target after the last entry, end still says not reached
		send_start(64'd0, 32'd5, 64'd1);
		send_byte(8'd1);
		send_item(OP_END, noise_fields());

		// start while a query is open, then an immediate hit
		send_start(64'd10, 32'd1, 64'd20);
		send_byte(8'd3);
		send_start(64'd0, 32'd9, 64'd0);
		send_byte(CODE_LONG);

		// random queries
		while (items_sent < ITEM_TOTAL) begin
			if (items_sent < ITEM_TOTAL / 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 52;
			end else if (items_sent < 2 * ITEM_TOTAL / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!pressure_done) begin
					hold_req = 1'b1;
					pressure_done = 1'b1;
				end
			end

			r = $urandom_range(99);
			if (r < 6) begin
				// noise between queries
				if ($urandom_range(1))
					send_item(OP_ILLEGAL, noise_fields());
				else
					send_byte(8'($urandom));
			end else begin
				r = $urandom_range(99);
				spc = (r < 70) ? 64'($urandom_range(0, 1000)) : rand64();
				r = $urandom_range(99);
				if (r < 75)
					tpc = spc + 64'($urandom_range(0, 40));
				else if (r < 90)
					tpc = rand64();
				else
					tpc = spc - 64'($urandom_range(0, 5));
				send_start(spc, $urandom, tpc);
				n = $urandom_range(0, 24);
				repeat (n) begin
					if ($urandom_range(99) < 3)
						send_item(OP_ILLEGAL, noise_fields());
					else
						send_byte(pick_code());
				end
				// most queries close with an end, the rest are cut by the next start
				if ($urandom_range(99) < 75)
					send_item(OP_END, noise_fields());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (sb.answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.answers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
